[sv/hsv_to_rgb_converter_unit_assert.svh]
// Assertion macros for the HSV to RGB converter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HSVRGB_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("hsvrgb: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HSVRGB_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("hsvrgb: next-cycle check failed");

`endif

[sv/hsvrgb_pkg.sv]
`default_nettype none

package hsvrgb_pkg;

    // Hue resolution: the hue arrives in units of 2^-HUE_FRAC_BITS degree.
    localparam int HUE_FRAC_BITS = 6;
    localparam int HUE_W         = 15;
    localparam int CH_W          = 8;
    localparam int CH_MAX        = (1 << CH_W) - 1;

    localparam int SECTOR_SPAN = 60 << HUE_FRAC_BITS;
    localparam int HUE_CIRCLE  = 360 << HUE_FRAC_BITS;
    localparam int POS_W       = $clog2(SECTOR_SPAN + 1);
    localparam int PROD8_W     = 2 * CH_W;

    // Each channel is a numerator over CH_MAX * SECTOR_SPAN.
    localparam int NUM_MAX    = CH_MAX * CH_MAX * SECTOR_SPAN;
    localparam int NUM_W      = $clog2(NUM_MAX + 1);
    localparam int ROUND_BIAS = CH_MAX * SECTOR_SPAN;
    localparam int X_W        = $clog2(2 * NUM_MAX + ROUND_BIAS + 1);

    // The rounding divisor 2 * CH_MAX * SECTOR_SPAN equals DIV_ODD << DIV_SHIFT.
    localparam int DIV_SHIFT = HUE_FRAC_BITS + 3;
    localparam int DIV_ODD   = CH_MAX * 15;
    localparam int Y_W       = X_W - DIV_SHIFT;
    localparam int RECIP     = (1 << Y_W) / DIV_ODD;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PROD_W    = Y_W + RECIP_W;
    localparam int REM_W     = $clog2(2 * DIV_ODD);

    typedef logic [HUE_W-1:0]   hue_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [CH_W-1:0]    ch_t;
    typedef logic [PROD8_W-1:0] prod8_t;
    typedef logic [NUM_W-1:0]   num_t;
    typedef logic [X_W-1:0]     x_t;
    typedef logic [Y_W-1:0]     y_t;
    typedef logic [PROD_W-1:0]  prod_t;
    typedef logic [REM_W-1:0]   rem_t;

    typedef struct packed {
        ch_t red;
        ch_t green;
        ch_t blue;
    } rgb_t;

    typedef enum logic [2:0] {
        SEC_RED_YELLOW    = 3'd0,
        SEC_YELLOW_GREEN  = 3'd1,
        SEC_GREEN_CYAN    = 3'd2,
        SEC_CYAN_BLUE     = 3'd3,
        SEC_BLUE_MAGENTA  = 3'd4,
        SEC_MAGENTA_RED   = 3'd5
    } sector_t;

    // In odd sectors the position within the sector counts down.
    function automatic logic sector_falling(sector_t sec);
        return sec inside {SEC_YELLOW_GREEN, SEC_CYAN_BLUE, SEC_MAGENTA_RED};
    endfunction

endpackage

`default_nettype wire

[sv/hsvrgb_ifs.sv]
`default_nettype none

interface hsvrgb_hsv_if;
    logic              valid;
    logic              ready;
    hsvrgb_pkg::hue_t  hue;
    hsvrgb_pkg::ch_t   saturation;
    hsvrgb_pkg::ch_t   value;

    modport source (output valid, output hue, output saturation, output value, input ready);
    modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

interface hsvrgb_rgb_if;
    logic             valid;
    logic             ready;
    hsvrgb_pkg::ch_t  red;
    hsvrgb_pkg::ch_t  green;
    hsvrgb_pkg::ch_t  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

[sv/hsv_to_rgb_converter_unit.sv]
// Channel  Direction  Payload                          Handshake
// hsv      in         hue[15], saturation[8], value[8]  valid/ready, beat on both high
// rgb      out        red[8], green[8], blue[8]         valid/ready, beat on both high
//
// One beat is accepted every cycle while hsv.ready is high.
// The rate is set by the pipeline stages, which advance as one unit.
// rst_n clears only the valid bits of the pipeline, the output register and the skid register.
// When rgb stalls, one more result drops into the skid register and then hsv.ready falls;
// hsv.ready comes from a register only, so no combinational path joins ready across the block.
`default_nettype none
`include "hsv_to_rgb_converter_unit_assert.svh"

module hsv_to_rgb_converter_unit
(
    input wire logic clk,
    input wire logic rst_n,
    hsvrgb_hsv_if.sink   hsv,
    hsvrgb_rgb_if.source rgb
);

    // The whole pipeline moves while the skid register is empty.
    logic en;

    // Stage 1: hue wrapped into one circle, the two 8x8 products.
    logic                  v1_reg;
    hsvrgb_pkg::hue_t      h1_reg;
    hsvrgb_pkg::hue_t      h1_next;
    hsvrgb_pkg::ch_t       val1_reg;
    hsvrgb_pkg::prod8_t    vs1_reg;
    hsvrgb_pkg::prod8_t    vs1_next;
    hsvrgb_pkg::prod8_t    vn1_reg;
    hsvrgb_pkg::prod8_t    vn1_next;

    // Stage 2: sector and the position factor.
    logic                  v2_reg;
    hsvrgb_pkg::sector_t   sec2_reg;
    hsvrgb_pkg::sector_t   sec2_next;
    hsvrgb_pkg::hue_t      sec_start;
    hsvrgb_pkg::pos_t      pos;
    hsvrgb_pkg::pos_t      f2_reg;
    hsvrgb_pkg::pos_t      f2_next;
    hsvrgb_pkg::ch_t       val2_reg;
    hsvrgb_pkg::prod8_t    vs2_reg;
    hsvrgb_pkg::prod8_t    vn2_reg;

    // Stage 3: numerators over CH_MAX * SECTOR_SPAN.
    logic                  v3_reg;
    hsvrgb_pkg::sector_t   sec3_reg;
    hsvrgb_pkg::ch_t       val3_reg;
    hsvrgb_pkg::num_t      base3_reg;
    hsvrgb_pkg::num_t      base3_next;
    hsvrgb_pkg::num_t      mix3_reg;
    hsvrgb_pkg::num_t      mix3_next;

    // Stage 4: rounded dividends with the power-of-two part of the divisor removed.
    logic                  v4_reg;
    hsvrgb_pkg::sector_t   sec4_reg;
    hsvrgb_pkg::ch_t       val4_reg;
    hsvrgb_pkg::x_t        xlo;
    hsvrgb_pkg::x_t        xmid;
    hsvrgb_pkg::y_t        ylo4_reg;
    hsvrgb_pkg::y_t        ymid4_reg;

    // Stages 5 and 6 live inside the two dividers; sector and value ride alongside.
    logic                  v5_reg;
    hsvrgb_pkg::sector_t   sec5_reg;
    hsvrgb_pkg::ch_t       val5_reg;
    logic                  v6_reg;
    hsvrgb_pkg::sector_t   sec6_reg;
    hsvrgb_pkg::ch_t       val6_reg;
    hsvrgb_pkg::ch_t       q_low;
    hsvrgb_pkg::ch_t       q_mid;
    hsvrgb_pkg::rgb_t      pix;

    // Output register and skid register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;
    logic                  load_out;
    logic                  load_skid;
    logic                  from_skid;
    hsvrgb_pkg::rgb_t      out_data_reg;
    hsvrgb_pkg::rgb_t      skid_data_reg;

    assign en        = !skid_valid_reg;
    assign hsv.ready = en;

    // ---------------------------------------------------------------- stage 1
    // The hue field stays below two circles, so one subtraction wraps it.
    assign h1_next  = (hsv.hue >= hsvrgb_pkg::hue_t'(hsvrgb_pkg::HUE_CIRCLE))
                    ? hsv.hue - hsvrgb_pkg::hue_t'(hsvrgb_pkg::HUE_CIRCLE)
                    : hsv.hue;
    assign vs1_next = hsvrgb_pkg::prod8_t'(hsv.value) * hsvrgb_pkg::prod8_t'(hsv.saturation);
    assign vn1_next = hsvrgb_pkg::prod8_t'(hsv.value)
                    * hsvrgb_pkg::prod8_t'(hsvrgb_pkg::ch_t'(hsvrgb_pkg::CH_MAX) - hsv.saturation);

    // ---------------------------------------------------------------- stage 2
    // A hue exactly on a boundary belongs to the higher sector.
    always_comb
    begin
        sec2_next = hsvrgb_pkg::SEC_RED_YELLOW;
        if (h1_reg >= hsvrgb_pkg::hue_t'(1 * hsvrgb_pkg::SECTOR_SPAN))
            sec2_next = hsvrgb_pkg::SEC_YELLOW_GREEN;
        if (h1_reg >= hsvrgb_pkg::hue_t'(2 * hsvrgb_pkg::SECTOR_SPAN))
            sec2_next = hsvrgb_pkg::SEC_GREEN_CYAN;
        if (h1_reg >= hsvrgb_pkg::hue_t'(3 * hsvrgb_pkg::SECTOR_SPAN))
            sec2_next = hsvrgb_pkg::SEC_CYAN_BLUE;
        if (h1_reg >= hsvrgb_pkg::hue_t'(4 * hsvrgb_pkg::SECTOR_SPAN))
            sec2_next = hsvrgb_pkg::SEC_BLUE_MAGENTA;
        if (h1_reg >= hsvrgb_pkg::hue_t'(5 * hsvrgb_pkg::SECTOR_SPAN))
            sec2_next = hsvrgb_pkg::SEC_MAGENTA_RED;
    end

    always_comb
    begin
        case (sec2_next)
            hsvrgb_pkg::SEC_RED_YELLOW:   sec_start = hsvrgb_pkg::hue_t'(0);
            hsvrgb_pkg::SEC_YELLOW_GREEN: sec_start = hsvrgb_pkg::hue_t'(1 * hsvrgb_pkg::SECTOR_SPAN);
            hsvrgb_pkg::SEC_GREEN_CYAN:   sec_start = hsvrgb_pkg::hue_t'(2 * hsvrgb_pkg::SECTOR_SPAN);
            hsvrgb_pkg::SEC_CYAN_BLUE:    sec_start = hsvrgb_pkg::hue_t'(3 * hsvrgb_pkg::SECTOR_SPAN);
            hsvrgb_pkg::SEC_BLUE_MAGENTA: sec_start = hsvrgb_pkg::hue_t'(4 * hsvrgb_pkg::SECTOR_SPAN);
            hsvrgb_pkg::SEC_MAGENTA_RED:  sec_start = hsvrgb_pkg::hue_t'(5 * hsvrgb_pkg::SECTOR_SPAN);
            default:                      sec_start = hsvrgb_pkg::hue_t'(0);
        endcase
    end

    assign pos     = hsvrgb_pkg::pos_t'(h1_reg - sec_start);
    assign f2_next = hsvrgb_pkg::sector_falling(sec2_next)
                   ? hsvrgb_pkg::pos_t'(hsvrgb_pkg::SECTOR_SPAN) - pos
                   : pos;

    // ---------------------------------------------------------------- stage 3
    // The offset part scales by the sector span; the mixed part by the position factor.
    assign base3_next = hsvrgb_pkg::num_t'(vn2_reg) * hsvrgb_pkg::num_t'(hsvrgb_pkg::SECTOR_SPAN);
    assign mix3_next  = hsvrgb_pkg::num_t'(vs2_reg) * hsvrgb_pkg::num_t'(f2_reg);

    // ---------------------------------------------------------------- stage 4
    // Round half up: floor((2n + d) / 2d), and 2d is an odd constant times a power of two.
    assign xlo  = (hsvrgb_pkg::x_t'(base3_reg) << 1) + hsvrgb_pkg::x_t'(hsvrgb_pkg::ROUND_BIAS);
    assign xmid = ((hsvrgb_pkg::x_t'(base3_reg) + hsvrgb_pkg::x_t'(mix3_reg)) << 1)
                + hsvrgb_pkg::x_t'(hsvrgb_pkg::ROUND_BIAS);

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= hsv.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_reg    <= h1_next;
            val1_reg  <= hsv.value;
            vs1_reg   <= vs1_next;
            vn1_reg   <= vn1_next;

            sec2_reg  <= sec2_next;
            f2_reg    <= f2_next;
            val2_reg  <= val1_reg;
            vs2_reg   <= vs1_reg;
            vn2_reg   <= vn1_reg;

            sec3_reg  <= sec2_reg;
            val3_reg  <= val2_reg;
            base3_reg <= base3_next;
            mix3_reg  <= mix3_next;

            sec4_reg  <= sec3_reg;
            val4_reg  <= val3_reg;
            ylo4_reg  <= xlo[hsvrgb_pkg::X_W-1:hsvrgb_pkg::DIV_SHIFT];
            ymid4_reg <= xmid[hsvrgb_pkg::X_W-1:hsvrgb_pkg::DIV_SHIFT];

            sec5_reg  <= sec4_reg;
            val5_reg  <= val4_reg;
            sec6_reg  <= sec5_reg;
            val6_reg  <= val5_reg;
        end
    end

    // ---------------------------------------------------------------- stages 5 and 6
    hsvrgb_div u_div_low
    (
        .clk (clk),
        .en  (en),
        .y   (ylo4_reg),
        .q   (q_low)
    );

    hsvrgb_div u_div_mid
    (
        .clk (clk),
        .en  (en),
        .y   (ymid4_reg),
        .q   (q_mid)
    );

    // The full channel is the value itself; the sector decides which channel gets what.
    always_comb
    begin
        case (sec6_reg)
            hsvrgb_pkg::SEC_RED_YELLOW:   pix = '{red: val6_reg, green: q_mid,    blue: q_low};
            hsvrgb_pkg::SEC_YELLOW_GREEN: pix = '{red: q_mid,    green: val6_reg, blue: q_low};
            hsvrgb_pkg::SEC_GREEN_CYAN:   pix = '{red: q_low,    green: val6_reg, blue: q_mid};
            hsvrgb_pkg::SEC_CYAN_BLUE:    pix = '{red: q_low,    green: q_mid,    blue: val6_reg};
            hsvrgb_pkg::SEC_BLUE_MAGENTA: pix = '{red: q_mid,    green: q_low,    blue: val6_reg};
            hsvrgb_pkg::SEC_MAGENTA_RED:  pix = '{red: val6_reg, green: q_low,    blue: q_mid};
            default:                      pix = '{red: val6_reg, green: q_low,    blue: q_mid};
        endcase
    end

    // ---------------------------------------------------------------- output and skid
    // A held skid beat always goes out first; a new beat goes to the output register when
    // that is free or being drained, and to the skid register otherwise.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        from_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (rgb.ready)
            begin
                load_out        = 1'b1;
                from_skid       = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (v6_reg)
        begin
            if (!out_valid_reg || rgb.ready)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (rgb.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= from_skid ? skid_data_reg : pix;
        if (load_skid)
            skid_data_reg <= pix;
    end

    assign rgb.valid = out_valid_reg;
    assign rgb.red   = out_data_reg.red;
    assign rgb.green = out_data_reg.green;
    assign rgb.blue  = out_data_reg.blue;

    // ---------------------------------------------------------------- assertions
    // The skid register only fills behind a held output beat.
    `HSVRGB_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // A finished beat arriving at a stalled output is caught by the skid register.
    `HSVRGB_ASSERT_NEXT(a_stall_catch, !skid_valid_reg && v6_reg && out_valid_reg && !rgb.ready,
        skid_valid_reg)
    // The rounded channels are ordered: offset, then mixed, then the full value.
    `HSVRGB_ASSERT_IMP(a_channel_order, v6_reg, (q_low <= q_mid) && (q_mid <= val6_reg))

endmodule

`default_nettype wire

[sv/hsvrgb_div.sv]
`default_nettype none

// Divides y by DIV_ODD with a reciprocal multiply and one correction step.
// Two register stages; the quotient is formed combinationally from the second one.
module hsvrgb_div
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire hsvrgb_pkg::y_t   y,
    output      hsvrgb_pkg::ch_t  q
);

    hsvrgb_pkg::y_t    y_a_reg;
    hsvrgb_pkg::prod_t prod_a_reg;
    hsvrgb_pkg::prod_t prod_next;
    hsvrgb_pkg::ch_t   q0_b_reg;
    hsvrgb_pkg::ch_t   q0_next;
    hsvrgb_pkg::rem_t  r_b_reg;
    hsvrgb_pkg::rem_t  r_next;

    assign prod_next = hsvrgb_pkg::prod_t'(y) * hsvrgb_pkg::prod_t'(hsvrgb_pkg::RECIP);

    // The estimate is the true quotient or one below it.
    assign q0_next = prod_a_reg[hsvrgb_pkg::Y_W + hsvrgb_pkg::CH_W - 1 : hsvrgb_pkg::Y_W];
    assign r_next  = hsvrgb_pkg::rem_t'(y_a_reg - hsvrgb_pkg::y_t'(q0_next)
                                        * hsvrgb_pkg::y_t'(hsvrgb_pkg::DIV_ODD));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_a_reg    <= y;
            prod_a_reg <= prod_next;
            q0_b_reg   <= q0_next;
            r_b_reg    <= r_next;
        end
    end

    assign q = q0_b_reg + hsvrgb_pkg::ch_t'(r_b_reg >= hsvrgb_pkg::rem_t'(hsvrgb_pkg::DIV_ODD));

endmodule

`default_nettype wire
